// File: src/u16u8_pkg.sv
package u16u8_pkg;

	localparam int RunMax            = 6;
	localparam int QueueDepthDefault = 2;

	localparam logic [15:0] HighFirst = 16'hD800;
	localparam logic [15:0] HighLast  = 16'hDBFF;
	localparam logic [15:0] LowFirst  = 16'hDC00;
	localparam logic [15:0] LowLast   = 16'hDFFF;

	localparam logic [20:0] ScalarRepl  = 21'h00FFFD;
	localparam logic [20:0] ScalarBom   = 21'h00FEFF;
	localparam logic [20:0] ScalarPlane = 21'h010000;
	localparam logic [20:0] Lim1        = 21'h000080;
	localparam logic [20:0] Lim2        = 21'h000800;
	localparam logic [20:0] Lim3        = 21'h010000;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [RunMax-1:0][7:0] bytes;
		logic [2:0]             count;
	} run_t;

	function automatic logic [2:0] enc_len(logic [20:0] s);
		logic [2:0] n;
		if (s < Lim1) begin
			n = 3'd1;
		end else if (s < Lim2) begin
			n = 3'd2;
		end else if (s < Lim3) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// byte 0 goes out first
	function automatic logic [3:0][7:0] enc_bytes(logic [20:0] s);
		logic [3:0][7:0] b;
		b = '0;
		if (s < Lim1) begin
			b[0] = {1'b0, s[6:0]};
		end else if (s < Lim2) begin
			b[0] = {3'b110, s[10:6]};
			b[1] = {2'b10, s[5:0]};
		end else if (s < Lim3) begin
			b[0] = {4'b1110, s[15:12]};
			b[1] = {2'b10, s[11:6]};
			b[2] = {2'b10, s[5:0]};
		end else begin
			b[0] = {5'b11110, s[20:18]};
			b[1] = {2'b10, s[17:12]};
			b[2] = {2'b10, s[11:6]};
			b[3] = {2'b10, s[5:0]};
		end
		return b;
	endfunction

	function automatic run_t run_append(run_t r, logic [20:0] s);
		run_t            o;
		logic [3:0][7:0] e;
		logic [2:0]      n;
		o = r;
		e = enc_bytes(s);
		n = enc_len(s);
		for (int j = 0; j < RunMax; j++) begin
			if (j >= int'(r.count) && j < int'(r.count) + int'(n)) begin
				o.bytes[j] = e[2'(j - int'(r.count))];
			end
		end
		o.count = r.count + n;
		return o;
	endfunction

endpackage

// File: src/utf16_to_utf8_encoder_core.sv
// The first byte of a unit is registered in the queue and then in the output stage before it is valid.
// Throughput: one UTF-8 byte per cycle from the output serializer while utf8_stall is low;
//   a unit yields n bytes (typically 1 to 3, at most 6) and holds the serializer until all are out.
// Units that yield no byte are absorbed by the front and never enter the queue.
// Reset: no surrogate held, new text pending, byte order mark off, queue empty.
module utf16_to_utf8_encoder_core #(
	parameter int QueueDepth = u16u8_pkg::QueueDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic                 utf16_valid,
	output logic                 utf16_stall,
	input  u16u8_pkg::in_item_t  utf16_beat,
	output logic                 utf8_valid,
	input  logic                 utf8_stall,
	output u16u8_pkg::out_item_t utf8_beat
);
	import u16u8_pkg::*;

	logic push;
	run_t push_run;
	logic q_full;
	logic pop;
	logic head_valid;
	run_t head_run;

	u16u8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.utf16_valid (utf16_valid),
		.utf16_stall (utf16_stall),
		.utf16_beat  (utf16_beat),
		.q_full      (q_full),
		.push        (push),
		.push_run    (push_run)
	);

	u16u8_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_run   (push_run),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_run   (head_run)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_run   (head_run),
		.pop        (pop),
		.utf8_valid (utf8_valid),
		.utf8_stall (utf8_stall),
		.utf8_beat  (utf8_beat)
	);

endmodule

// File: src/u16u8_front.sv
module u16u8_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                utf16_valid,
	output logic                utf16_stall,
	input  u16u8_pkg::in_item_t utf16_beat,
	input  logic                q_full,
	output logic                push,
	output u16u8_pkg::run_t     push_run
);
	import u16u8_pkg::*;

	logic       emit_bom_q;
	logic       held_q;
	logic [9:0] held_bits_q;
	logic       started_q;

	logic       accept;
	logic       is_high;
	logic       is_low;
	logic       held_d;
	logic [9:0] held_bits_d;
	logic       started_d;
	run_t       run;

	assign cfg_ready   = 1'b1;
	assign utf16_stall = q_full;
	assign accept      = utf16_valid && !q_full;

	always_comb begin
		is_high     = utf16_beat.code_unit inside {[HighFirst:HighLast]};
		is_low      = utf16_beat.code_unit inside {[LowFirst:LowLast]};
		run         = '0;
		held_d      = held_q;
		held_bits_d = held_bits_q;
		started_d   = 1'b1;
		if (!started_q && emit_bom_q) begin
			run = run_append(run, ScalarBom);
		end
		if (held_q && is_low) begin
			run    = run_append(run, ScalarPlane + 21'({held_bits_q, utf16_beat.code_unit[9:0]}));
			held_d = 1'b0;
		end else begin
			if (held_q) begin
				run = run_append(run, ScalarRepl);
			end
			held_d = 1'b0;
			if (is_high) begin
				held_d      = 1'b1;
				held_bits_d = utf16_beat.code_unit[9:0];
			end else if (is_low) begin
				run = run_append(run, ScalarRepl);
			end else begin
				run = run_append(run, 21'(utf16_beat.code_unit));
			end
		end
		if (utf16_beat.end_of_text) begin
			if (held_d) begin
				run = run_append(run, ScalarRepl);
			end
			held_d      = 1'b0;
			held_bits_d = '0;
			started_d   = 1'b0;
		end
	end

	assign push     = accept && (run.count != 3'd0);
	assign push_run = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_bom_q  <= 1'b0;
			held_q      <= 1'b0;
			held_bits_q <= '0;
			started_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				emit_bom_q <= cfg_data;
			end
			if (accept) begin
				held_q      <= held_d;
				held_bits_q <= held_bits_d;
				started_q   <= started_d;
			end
		end
	end

endmodule

// File: src/u16u8_queue.sv
module u16u8_queue #(
	parameter int Depth = u16u8_pkg::QueueDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u16u8_pkg::run_t push_run,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output u16u8_pkg::run_t head_run
);
	import u16u8_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	run_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_pop;

	assign full       = (cnt_q == CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_run   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/u16u8_back.sv
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  u16u8_pkg::run_t      head_run,
	output logic                 pop,
	output logic                 utf8_valid,
	input  logic                 utf8_stall,
	output u16u8_pkg::out_item_t utf8_beat
);
	import u16u8_pkg::*;

	logic       valid_q;
	out_item_t  beat_q;
	logic [2:0] idx_q;
	logic       load;
	logic       last;

	assign load = !valid_q || !utf8_stall;
	assign last = (idx_q == head_run.count - 3'd1);
	assign pop  = load && head_valid && last;

	assign utf8_valid = valid_q;
	assign utf8_beat  = beat_q;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			beat_q.out_byte    <= head_run.bytes[idx_q];
			beat_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

endmodule
